### rtl/radix_digit_formatter_top_assert.svh
// assertion macros for the radix digit formatter checker
// used by rdf_checker, expects a clock named aclk and reset aresetn in scope
`ifndef RADIX_DIGIT_FORMATTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_FORMATTER_TOP_ASSERT_SVH

// condition implies property in the same cycle
`define RDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("radix_digit_formatter_top: same-cycle check failed");

// condition implies property in the next cycle
`define RDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("radix_digit_formatter_top: next-cycle check failed");

`endif

### rtl/rdf_pkg.sv
// shared types, constants and helper functions for the radix digit formatter
// no dependencies
`timescale 1ns / 1ps

package rdf_pkg;

    localparam int DEF_VALUE_WIDTH = 64;

    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int SEP_W     = 21;
    localparam int GRP_W     = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'd55;   // 'A' - 10

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GROUP_BASED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GROUP_PLAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SEP_BASED   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEP_PLAIN   = 2'd3;

    localparam logic [GRP_W-1:0] RST_GROUP_BASED = 7'd4;
    localparam logic [GRP_W-1:0] RST_GROUP_PLAIN = 7'd3;
    localparam logic [SEP_W-1:0] RST_SEP_BASED   = 21'd32;
    localparam logic [SEP_W-1:0] RST_SEP_PLAIN   = 21'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SHOW,
        ST_HOLD
    } rdf_state_t;

    typedef struct packed {
        logic start;
    } rdf_div_ctrl_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } rdf_div_stat_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d7;
        d7 = {1'b0, d};
        return (d < DEC_DIGITS) ? d7 + ASCII_ZERO : d7 + ASCII_ALPHA;
    endfunction

endpackage

### rtl/rdf_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on rdf_pkg
`timescale 1ns / 1ps

module rdf_divider #(
    parameter int VALUE_WIDTH = rdf_pkg::DEF_VALUE_WIDTH,
    parameter int STEP_W      = $clog2(VALUE_WIDTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rdf_pkg::rdf_div_ctrl_t         ctrl,
    input  logic [VALUE_WIDTH-1:0]         dividend,
    input  logic [rdf_pkg::RADIX_W-1:0]    divisor,
    output logic [VALUE_WIDTH-1:0]         quotient,
    output logic [rdf_pkg::RADIX_W-1:0]    remainder,
    output rdf_pkg::rdf_div_stat_t         stat
);

    logic [VALUE_WIDTH-1:0]      dvd_reg, dvd_next;
    logic [rdf_pkg::RADIX_W-1:0] rem_reg, rem_next;
    logic [rdf_pkg::RADIX_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [rdf_pkg::RADIX_W:0]   trial;
    logic [rdf_pkg::RADIX_W:0]   diff;
    logic                        fits;

    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // quotient bits shift in behind the dividend bits
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? diff[rdf_pkg::RADIX_W-1:0] : trial[rdf_pkg::RADIX_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
    end

    assign quotient       = dvd_reg;
    assign remainder      = rem_reg;
    assign stat.done      = done_reg;
    assign stat.quot_zero = (dvd_reg == '0);

endmodule

### rtl/rdf_digit_buf.sv
// digit store: one write port, one registered read port
// depends on rdf_pkg
`timescale 1ns / 1ps

module rdf_digit_buf #(
    parameter int DEPTH  = rdf_pkg::DEF_VALUE_WIDTH,
    parameter int DATA_W = rdf_pkg::RADIX_W + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/radix_digit_formatter_top.sv
// radix digit formatter: sequencer, configuration registers and output register
// depends on rdf_pkg, rdf_divider, rdf_digit_buf
`timescale 1ns / 1ps

// usage
//   input words on s_*: a magnitude, a radix (clamped to 2..36) and two flags in
//   s_tuser. each word yields one output word per digit on m_*, most significant
//   digit first, m_tlast on the least significant digit.
//   group sizes and separator codepoints come from the cfg_wr_* port; write them
//   only while no word is in progress.
// timing
//   the block holds one word at a time; s_tready is high only while idle.
//   each digit costs one pass of the shared bit-serial divider, and each
//   emitted digit passes through the READ, SHOW and HOLD states, HOLD waiting
//   out any receiver stall. all digits are divided before the first appears.
// reset
//   aresetn (synchronous, active low) returns the sequencer to idle, drops
//   m_tvalid and loads the register defaults (groups of 4 based, 3 plain,
//   separator 32). a stalled output word holds until m_tready.

module radix_digit_formatter_top #(
    parameter int VALUE_WIDTH = rdf_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [rdf_pkg::CFG_ADDR_W-1:0]    cfg_wr_addr,
    input  logic [rdf_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [71:0]                       s_tdata,   // magnitude[63:0], radix[69:64], pad
    input  logic [1:0]                        s_tuser,   // based_style[0], editing_mode[1]
    // output words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // digit_char[6:0],
                                                         // separator_follows[7],
                                                         // separator_code[28:8], pad
    output logic                              m_tlast
);

    localparam int IDX_W  = $clog2(VALUE_WIDTH);
    localparam int ENTRY_W = rdf_pkg::RADIX_W + 1;

    // configuration registers
    logic [rdf_pkg::GRP_W-1:0] grp_based_reg, grp_plain_reg;
    logic [rdf_pkg::SEP_W-1:0] sep_based_reg, sep_plain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_based_reg <= rdf_pkg::RST_GROUP_BASED;
            grp_plain_reg <= rdf_pkg::RST_GROUP_PLAIN;
            sep_based_reg <= rdf_pkg::RST_SEP_BASED;
            sep_plain_reg <= rdf_pkg::RST_SEP_PLAIN;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                rdf_pkg::REG_GROUP_BASED: grp_based_reg <= cfg_wr_data[rdf_pkg::GRP_W-1:0];
                rdf_pkg::REG_GROUP_PLAIN: grp_plain_reg <= cfg_wr_data[rdf_pkg::GRP_W-1:0];
                rdf_pkg::REG_SEP_BASED:   sep_based_reg <= cfg_wr_data;
                rdf_pkg::REG_SEP_PLAIN:   sep_plain_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    rdf_pkg::rdf_state_t state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic [rdf_pkg::GRP_W-1:0] grp_reg, grp_next;
    logic [rdf_pkg::GRP_W-1:0] grp_inc;

    // per-word settings
    logic [rdf_pkg::RADIX_W-1:0] radix_reg;
    logic [rdf_pkg::GRP_W-1:0]   spacing_reg;
    logic [rdf_pkg::SEP_W-1:0]   sepcode_reg;

    // output register
    logic [rdf_pkg::CHAR_W-1:0]  out_char_reg;
    logic                        out_sep_reg;
    logic [rdf_pkg::SEP_W-1:0]   out_code_reg;
    logic                        out_last_reg;

    logic                        accept;
    logic [rdf_pkg::RADIX_W-1:0] in_radix;
    logic                        in_based;
    logic                        in_editing;

    rdf_pkg::rdf_div_ctrl_t      div_ctrl;
    rdf_pkg::rdf_div_stat_t      div_stat;
    logic [VALUE_WIDTH-1:0]      div_dividend;
    logic [rdf_pkg::RADIX_W-1:0] div_divisor;
    logic [VALUE_WIDTH-1:0]      div_quot;
    logic [rdf_pkg::RADIX_W-1:0] div_rem;

    logic                        buf_wr_en;
    logic [ENTRY_W-1:0]          buf_wr_data;
    logic [ENTRY_W-1:0]          buf_rd_data;
    logic                        sep_here;

    assign in_radix   = rdf_pkg::clamp_radix(s_tdata[69:64]);
    assign in_based   = s_tuser[0];
    assign in_editing = s_tuser[1];
    assign s_tready   = (state_reg == rdf_pkg::ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    // separator after digit i when grouping is on, i >= 1 and i mod spacing is 0
    assign sep_here    = (spacing_reg != '0) && (cnt_reg != '0) && (grp_reg == '0);
    assign buf_wr_data = {sep_here, div_rem};
    assign grp_inc     = grp_reg + rdf_pkg::GRP_W'(1);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        grp_next       = grp_reg;
        div_ctrl.start = 1'b0;
        div_dividend   = div_quot;
        div_divisor    = radix_reg;
        buf_wr_en      = 1'b0;
        case (state_reg)
            rdf_pkg::ST_IDLE: begin
                div_dividend = s_tdata[VALUE_WIDTH-1:0];
                div_divisor  = in_radix;
                if (s_tvalid) begin
                    div_ctrl.start = 1'b1;
                    cnt_next       = '0;
                    grp_next       = '0;
                    state_next     = rdf_pkg::ST_DIV;
                end
            end
            rdf_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    buf_wr_en = 1'b1;
                    if (div_stat.quot_zero || cnt_reg == IDX_W'(VALUE_WIDTH - 1)) begin
                        state_next = rdf_pkg::ST_READ;
                    end else begin
                        cnt_next       = cnt_reg + IDX_W'(1);
                        grp_next       = (grp_inc == spacing_reg) ? '0 : grp_inc;
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            rdf_pkg::ST_READ: begin
                state_next = rdf_pkg::ST_SHOW;
            end
            rdf_pkg::ST_SHOW: begin
                state_next = rdf_pkg::ST_HOLD;
            end
            rdf_pkg::ST_HOLD: begin
                if (m_tready) begin
                    if (cnt_reg == '0) begin
                        state_next = rdf_pkg::ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg - IDX_W'(1);
                        state_next = rdf_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = rdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdf_pkg::ST_IDLE;
            cnt_reg   <= '0;
            grp_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            radix_reg   <= in_radix;
            spacing_reg <= in_editing ? '0 : (in_based ? grp_based_reg : grp_plain_reg);
            sepcode_reg <= in_based ? sep_based_reg : sep_plain_reg;
        end
        if (state_reg == rdf_pkg::ST_SHOW) begin
            out_char_reg <= rdf_pkg::digit_ascii(buf_rd_data[rdf_pkg::RADIX_W-1:0]);
            out_sep_reg  <= buf_rd_data[ENTRY_W-1];
            out_code_reg <= buf_rd_data[ENTRY_W-1] ? sepcode_reg : '0;
            out_last_reg <= (cnt_reg == '0);
        end
    end

    rdf_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    rdf_digit_buf #(
        .DEPTH  (VALUE_WIDTH),
        .DATA_W (ENTRY_W)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (cnt_reg),
        .wr_data (buf_wr_data),
        .rd_addr (cnt_reg),
        .rd_data (buf_rd_data)
    );

    assign m_tvalid = (state_reg == rdf_pkg::ST_HOLD);
    assign m_tdata  = {3'b000, out_code_reg, out_sep_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

### rtl/rdf_checker.sv
// port-level checks for radix_digit_formatter_top, attached by bind
// depends on radix_digit_formatter_top_assert.svh
`timescale 1ns / 1ps

`include "radix_digit_formatter_top_assert.svh"

module rdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // one word in flight: never taking input while a digit is offered
    `RDF_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready)

    // after a word is taken the block stays busy
    `RDF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // stalled digit holds
    `RDF_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // digit char in 0-9 or A-Z
    `RDF_ASSERT_SAME(a_char_range, m_tvalid,
        (m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) ||
        (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd90))

    // no separator after the final digit, and code is zero when none follows
    `RDF_ASSERT_SAME(a_sep_code, m_tvalid && (m_tlast || !m_tdata[7]),
        !m_tdata[7] && m_tdata[28:8] == 21'd0)

endmodule

bind radix_digit_formatter_top rdf_checker u_rdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
